// ----- rtl/rcmr_pkg.sv -----
package rcmr_pkg;

	localparam int MAX_PIECE  = 8;
	localparam int MAX_LENGTH = 255;

	localparam int LEN_W       = 8;
	localparam int PRICE_W     = 10;
	localparam int REV_W       = 18;
	localparam int CFG_IDX_W   = 4;
	localparam int NUM_PRICE   = 8;
	localparam int WIN_DEPTH   = 8;
	localparam int SLOT_W      = $clog2(WIN_DEPTH);
	localparam int PIECE_CNT_W = $clog2(MAX_PIECE + 1);

	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [PRICE_W-1:0]     price_t;
	typedef logic [REV_W-1:0]       rev_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [PIECE_CNT_W-1:0] piece_cnt_t;

	localparam rev_t REV_MAX = {REV_W{1'b1}};

	localparam price_t PRICE_RESET [NUM_PRICE] = '{
		10'd1, 10'd5, 10'd8, 10'd9, 10'd10, 10'd17, 10'd17, 10'd20
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DRAIN
	} state_t;

	// sequencer to datapath control
	typedef struct packed {
		logic  win_clear;
		logic  acc_en;
		logic  j_done;
		logic  res_zero;
		logic  res_load;
		logic  out_load;
		slot_t rd_slot;
		slot_t wr_slot;
		slot_t piece_idx;
	} ctl_t;

endpackage

// ----- rtl/rod_cutting_max_revenue_core.sv -----
// rod cutting revenue engine
// input channel: in_valid/in_ready with rod_length (0..255); one transaction per rod
// output channel: out_valid/out_ready with best_revenue; exactly one transaction per rod
// config channel: cfg_valid/cfg_ready, cfg_index 0..7 picks the price of piece length 1..8,
//   cfg_data[9:0] is the price; indexes beyond the list are dropped; cfg_ready is always high
// work per rod: the sequencer visits every (length, piece) pair, with pieces up to
//   min(8, length), then moves the answer into the output register in the drain state;
//   a length of zero goes straight to the drain state with an answer of zero
// one rod at a time; the single add-and-compare unit is visited once per
//   (length, piece) pair
// the input is taken only while the sequencer is idle; a finished result sits in the output
//   register so a new rod can be taken while the receiver stalls, and a second result
//   waits in the drain state until the register is free
// reset: prices return to 1,5,8,9,10,17,17,20, sequencer idle, output empty
module rod_cutting_max_revenue_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rcmr_pkg::len_t     rod_length,
	output logic               out_valid,
	input  logic               out_ready,
	output rcmr_pkg::rev_t     best_revenue,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  rcmr_pkg::cfg_idx_t cfg_index,
	input  rcmr_pkg::price_t   cfg_data
);
	import rcmr_pkg::*;

	price_t price_q [NUM_PRICE];
	rev_t   win_q   [WIN_DEPTH];   // best of the last eight lengths, slot j mod 8
	rev_t   best_q;                // running maximum for the current length
	rev_t   res_q;                 // answer waiting for the output register
	rev_t   out_q;
	logic   out_valid_q;
	rev_t   new_best;
	logic   out_free;
	ctl_t   ctl;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign best_revenue = out_q;
	assign out_free     = !out_valid_q || out_ready;

	rcmr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rod_length(rod_length),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	// shared add-and-compare: price of this piece plus best of the remainder
	rcmr_addcmp u_addcmp (
		.price    (price_q[ctl.piece_idx]),
		.prev_best(win_q[ctl.rd_slot]),
		.acc_best (best_q),
		.new_best (new_best)
	);

	// price registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PRICE; k++) begin
				price_q[k] <= PRICE_RESET[k];
			end
		end else if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_PRICE)) begin
			price_q[cfg_index[SLOT_W-1:0]] <= cfg_data;
		end
	end

	// window and accumulator, cleared when a rod is taken
	always_ff @(posedge clk) begin
		if (ctl.win_clear) begin
			for (int k = 0; k < WIN_DEPTH; k++) begin
				win_q[k] <= '0;
			end
			best_q <= '0;
		end else if (ctl.acc_en) begin
			if (ctl.j_done) begin
				win_q[ctl.wr_slot] <= new_best;
				best_q             <= '0;
			end else begin
				best_q <= new_best;
			end
		end
	end

	// final answer, zero for an empty rod
	always_ff @(posedge clk) begin
		if (ctl.res_zero) begin
			res_q <= '0;
		end else if (ctl.res_load) begin
			res_q <= new_best;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q <= res_q;
		end
	end

endmodule

// ----- rtl/rcmr_addcmp.sv -----
module rcmr_addcmp (
	input  rcmr_pkg::price_t price,
	input  rcmr_pkg::rev_t   prev_best,
	input  rcmr_pkg::rev_t   acc_best,
	output rcmr_pkg::rev_t   new_best
);
	import rcmr_pkg::*;

	logic [REV_W:0] sum;
	rev_t           cand;

	// saturating add of piece price and earlier best
	assign sum  = {1'b0, prev_best} + {{(REV_W + 1 - PRICE_W){1'b0}}, price};
	assign cand = sum[REV_W] ? REV_MAX : sum[REV_W-1:0];

	assign new_best = (cand > acc_best) ? cand : acc_best;

endmodule

// ----- rtl/rcmr_seq.sv -----
module rcmr_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rcmr_pkg::len_t rod_length,
	input  logic          out_free,
	output rcmr_pkg::ctl_t ctl
);
	import rcmr_pkg::*;

	state_t     state_q, state_d;
	len_t       len_q;
	len_t       j_q;
	piece_cnt_t i_q;
	logic       accept;
	logic       last_i;
	logic       j_last;
	len_t       diff;
	len_t       len_sat;

	assign accept  = in_valid && in_ready;
	assign last_i  = (i_q == PIECE_CNT_W'(MAX_PIECE)) || (LEN_W'(i_q) == j_q);
	assign j_last  = (j_q == len_q);
	assign diff    = j_q - LEN_W'(i_q);
	assign len_sat = (32'(rod_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : rod_length;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (len_sat == '0) ? ST_DRAIN : ST_CALC;
				end
			end
			ST_CALC: begin
				if (last_i && j_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		ctl           = '0;
		ctl.rd_slot   = diff[SLOT_W-1:0];
		ctl.wr_slot   = j_q[SLOT_W-1:0];
		ctl.piece_idx = SLOT_W'(i_q - PIECE_CNT_W'(1));
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				ctl.win_clear = in_valid;
				ctl.res_zero  = in_valid;
			end
			ST_CALC: begin
				ctl.acc_en   = 1'b1;
				ctl.j_done   = last_i;
				ctl.res_load = last_i && j_last;
			end
			ST_DRAIN: begin
				ctl.out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			j_q     <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				len_q <= len_sat;
				j_q   <= LEN_W'(1);
				i_q   <= PIECE_CNT_W'(1);
			end else if (state_q == ST_CALC) begin
				if (last_i) begin
					i_q <= PIECE_CNT_W'(1);
					if (!j_last) begin
						j_q <= j_q + LEN_W'(1);
					end
				end else begin
					i_q <= i_q + PIECE_CNT_W'(1);
				end
			end
		end
	end

	// piece counter stays within the usable lengths
	a_piece_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |->
			(i_q >= PIECE_CNT_W'(1)) && (LEN_W'(i_q) <= j_q) &&
			(i_q <= PIECE_CNT_W'(MAX_PIECE)))
		else $error("piece counter out of range");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (j_q >= LEN_W'(1)) && (j_q <= len_q))
		else $error("length counter passed the rod length");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (rod_length == '0)) |=> (state_q == ST_DRAIN))
		else $error("zero length did not go straight to the result");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CALC) && last_i && j_last) |=> (state_q == ST_DRAIN))
		else $error("last step did not hand over the result");

endmodule

// ----- test/rod_cutting_max_revenue_core_tb.sv -----
module rod_cutting_max_revenue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcmr_pkg::*;

	// the longest rod's work passes with no transaction on any channel, plus stalls on both sides
	localparam int WATCHDOG_LIMIT = 12000;
	localparam int RANDOM_RODS    = 270;
	localparam int PHASES         = 8;
	localparam int RODS_PER_PHASE = (RANDOM_RODS + PHASES - 1) / PHASES;

	// kinds of row in the directed table
	typedef enum logic [1:0] {
		ROW_ROD,
		ROW_PRICE,
		ROW_ALL_PRICES
	} row_kind_e;

	// value is the rod length for a rod row, the price otherwise
	typedef struct packed {
		row_kind_e kind;
		cfg_idx_t  index;
		price_t    value;
		logic      known;
		rev_t      want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 26;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// reset prices: the classic revenue table
		'{ROW_ROD,        4'd0,  10'd0,    1'b1, 18'd0},
		'{ROW_ROD,        4'd0,  10'd1,    1'b1, 18'd1},
		'{ROW_ROD,        4'd0,  10'd2,    1'b1, 18'd5},
		'{ROW_ROD,        4'd0,  10'd3,    1'b1, 18'd8},
		'{ROW_ROD,        4'd0,  10'd4,    1'b1, 18'd10},
		'{ROW_ROD,        4'd0,  10'd8,    1'b1, 18'd22},
		'{ROW_ROD,        4'd0,  10'd9,    1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd128,  1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd255,  1'b0, 18'd0},
		// every price at its top: the largest revenue there is
		'{ROW_ALL_PRICES, 4'd0,  10'd1023, 1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd255,  1'b1, 18'd260865},
		'{ROW_ROD,        4'd0,  10'd1,    1'b1, 18'd1023},
		'{ROW_ROD,        4'd0,  10'd0,    1'b1, 18'd0},
		// indexes past the list must be dropped
		'{ROW_PRICE,      4'd8,  10'd0,    1'b0, 18'd0},
		'{ROW_PRICE,      4'd15, 10'd0,    1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd255,  1'b1, 18'd260865},
		// all prices zero
		'{ROW_ALL_PRICES, 4'd0,  10'd0,    1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd255,  1'b1, 18'd0},
		'{ROW_ROD,        4'd0,  10'd7,    1'b1, 18'd0},
		// only the longest piece is worth anything
		'{ROW_PRICE,      4'd7,  10'd1023, 1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd8,    1'b1, 18'd1023},
		'{ROW_ROD,        4'd0,  10'd16,   1'b1, 18'd2046},
		'{ROW_ROD,        4'd0,  10'd7,    1'b1, 18'd0},
		// unit pieces fill the remainder
		'{ROW_PRICE,      4'd0,  10'd3,    1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd200,  1'b0, 18'd0},
		'{ROW_ROD,        4'd0,  10'd255,  1'b0, 18'd0}
	};

	logic     clk        = 1'b0;
	logic     arst_n     = 1'b0;
	logic     in_valid   = 1'b0;
	logic     in_ready;
	len_t     rod_length = '0;
	logic     out_valid;
	logic     out_ready  = 1'b0;
	rev_t     best_revenue;
	logic     cfg_valid  = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index  = '0;
	price_t   cfg_data   = '0;

	// local copy of the price registers and the revenues still owed
	price_t price_now [NUM_PRICE];
	rev_t   revenue_due [$];

	int failures         = 0;
	int rods_sent        = 0;
	int revenues_checked = 0;
	int price_writes     = 0;
	int quiet_cycles     = 0;
	int idle_pct         = 0;
	int stall_pct        = 0;

	rod_cutting_max_revenue_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rod_length   (rod_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.best_revenue (best_revenue),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bottom-up revenue over a sliding window of the last eight lengths
	function automatic rev_t predict_revenue(input len_t len);
		rev_t        window [WIN_DEPTH];
		rev_t        best;
		rev_t        solved;
		int unsigned sum;
		int          span;
		span = int'(len);
		if (span > MAX_LENGTH) begin
			span = MAX_LENGTH;
		end
		foreach (window[k]) begin
			window[k] = '0;
		end
		solved = '0;
		for (int j = 1; j <= span; j++) begin
			best = '0;
			for (int i = 1; i <= MAX_PIECE && i <= j; i++) begin
				sum = price_now[i-1] + window[(j - i) % WIN_DEPTH];
				// saturate at the top of the revenue range
				if (sum > REV_MAX) begin
					sum = REV_MAX;
				end
				if (sum > best) begin
					best = rev_t'(sum);
				end
			end
			window[j % WIN_DEPTH] = best;
			solved = best;
		end
		return solved;
	endfunction

	// one rod transaction, with random gaps in front of it
	task automatic send_rod(input len_t len, input logic known, input rev_t want);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		rod_length <= len;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		revenue_due.push_back(known ? want : predict_revenue(len));
		rods_sent++;
	endtask

	// one register write; valid drops for a cycle after each transaction
	task automatic write_price(input cfg_idx_t index, input price_t value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (index < NUM_PRICE) begin
			price_now[index[SLOT_W-1:0]] = value;
		end
		price_writes++;
		@(posedge clk);
	endtask

	// hold the sender off until every revenue is back and the core is idle
	task automatic settle();
		in_valid <= 1'b0;
		while (revenue_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// compare each result transaction with the oldest owed revenue
	always @(posedge clk) begin
		rev_t want;
		if (arst_n && out_valid && out_ready) begin
			if (revenue_due.size() == 0) begin
				$error("best_revenue: unexpected transaction, expected none, actual %0d",
					best_revenue);
				failures++;
			end else begin
				want = revenue_due.pop_front();
				if (best_revenue !== want) begin
					$error("best_revenue: expected %0d, actual %0d", want, best_revenue);
					failures++;
				end
				revenues_checked++;
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t row;
		len_t      len;
		int        pick;
		int        keep;
		for (int k = 0; k < NUM_PRICE; k++) begin
			price_now[k] = PRICE_RESET[k];
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, run with no idling
		foreach (DIRECTED[n]) begin
			row = DIRECTED[n];
			case (row.kind)
				ROW_ROD: begin
					send_rod(len_t'(row.value), row.known, row.want);
				end
				ROW_PRICE: begin
					settle();
					write_price(row.index, row.value);
				end
				default: begin
					settle();
					for (int k = 0; k < NUM_PRICE; k++) begin
						write_price(cfg_idx_t'(k), row.value);
					end
				end
			endcase
		end
		settle();

		// random phases, each with its own idling mix and price set
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 61;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 61;
				end
				default: begin
					idle_pct = 18;
					stall_pct <= 18;
				end
			endcase

			keep = $urandom_range(NUM_PRICE - 1);
			for (int k = 0; k < NUM_PRICE; k++) begin
				case (phase % 4)
					0: write_price(cfg_idx_t'(k), price_t'($urandom_range(1023)));
					1: write_price(cfg_idx_t'(k), price_t'($urandom_range(31)));
					// top prices, then all prices zero
					2: write_price(cfg_idx_t'(k), (phase < 4) ? '1 : '0);
					default: write_price(cfg_idx_t'(k),
						(k == keep) ? price_t'($urandom_range(1023)) : '0);
				endcase
			end
			// a dropped write must not disturb the prices
			if ($urandom_range(1) == 1) begin
				write_price(cfg_idx_t'(NUM_PRICE + $urandom_range(7)),
					price_t'($urandom_range(1023)));
			end

			for (int item = 0; item < RODS_PER_PHASE; item++) begin
				// sender pauses until the core has drained
				if (item == RODS_PER_PHASE / 2 || $urandom_range(15) == 0) begin
					settle();
				end
				// mostly short rods, a few long ones
				pick = $urandom_range(99);
				if (pick < 70) begin
					len = len_t'($urandom_range(20));
				end else if (pick < 90) begin
					len = len_t'($urandom_range(100, 21));
				end else begin
					len = len_t'($urandom_range(255, 101));
				end
				send_rod(len, 1'b0, '0);
			end
			settle();
		end

		// let any stray transaction show up
		repeat (20) @(posedge clk);

		$display("rods of length 0 to 255, reset, extreme and random prices: %0d sent, %0d checked",
			rods_sent, revenues_checked);
		$display("%0d price writes incl. dropped indexes; idling none, 61/0, 0/61, 18/18",
			price_writes);
		if (failures == 0 && revenue_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
